// ===== rtl/beqscan_pkg.sv =====
// Package for the bit-packed equality count scan unit.
// Holds field widths, register indexes and the value select bundle.
// No dependencies.
package beqscan_pkg;

  // Field and datapath widths fixed by the packed column format.
  localparam int WORD_W     = 32;
  localparam int WORDS      = 4;
  localparam int VALS       = 32;
  localparam int SEL_W      = 6;
  localparam int BW_W       = 6;
  localparam int ROW_W      = 5;
  localparam int POS_W      = 10;
  localparam int CNT_W      = 40;
  localparam int LANE_CNT_W = 6;
  localparam int CFG_IDX_W  = 2;

  localparam logic [BW_W-1:0]  MAX_BW    = 6'd32;
  localparam logic [CNT_W-1:0] TOTAL_MAX = 40'hFF_FFFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_WIDTH    = 2'd0,
    REG_TARGET_VALUE = 2'd1
  } cfg_reg_t;

  // Per-item select information shared by every lane of a beat.
  typedef struct packed {
    logic [VALS-1:0]             en;
    logic [VALS-1:0][SEL_W-1:0]  sel;
    logic [WORD_W-1:0]           mask;
    logic [WORD_W-1:0]           target;
  } value_sel_t;

endpackage

// ===== rtl/beqscan_lane.sv =====
// Match logic for one lane: extracts the values ending in the current row
// and compares each against the target. Depends on beqscan_pkg.
module beqscan_lane (
  input  logic [beqscan_pkg::WORD_W-1:0] word,
  input  logic [beqscan_pkg::WORD_W-1:0] prev_word,
  input  beqscan_pkg::value_sel_t        vsel,
  output logic [beqscan_pkg::VALS-1:0]   hits
);

  logic [2*beqscan_pkg::WORD_W-1:0] window;

  // The previous row supplies the low part of a value that crosses rows.
  assign window = {word, prev_word};

  // One shifter and comparator per value position.
  always_comb begin
    logic [2*beqscan_pkg::WORD_W-1:0] shifted;
    shifted = '0;
    for (int p = 0; p < beqscan_pkg::VALS; p++) begin
      shifted = window >> vsel.sel[p];
      hits[p] = vsel.en[p] &&
                ((shifted[beqscan_pkg::WORD_W-1:0] & vsel.mask) == vsel.target);
    end
  end

endmodule

// ===== rtl/bitpacked_equality_count_scan_unit.sv =====
// A final count passes stages 1 to 3 and then the output register.
// Throughput: one beat of four packed words per cycle; the prior-row memory is
// read and rewritten at the same entry on the accept edge, so no stall arises.
// Input stalls only while stage 3 holds a final count and the output is full.
// Reset (rst_n low, synchronous) clears counters, totals, valids and registers
// to bit_width 1 and target 0; the prior-row memory is not cleared.
module bitpacked_equality_count_scan_unit #(
  parameter int LANES = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [beqscan_pkg::WORD_W-1:0]        in_word_a,
  input  logic [beqscan_pkg::WORD_W-1:0]        in_word_b,
  input  logic [beqscan_pkg::WORD_W-1:0]        in_word_c,
  input  logic [beqscan_pkg::WORD_W-1:0]        in_word_d,
  input  logic                                  in_last_item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [beqscan_pkg::CNT_W-1:0]         out_match_count,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [beqscan_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [beqscan_pkg::WORD_W-1:0]        cfg_data
);

  localparam int GROUPS   = LANES / beqscan_pkg::WORDS;
  localparam int GRP_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int ROW_BITS = beqscan_pkg::WORDS * beqscan_pkg::WORD_W;
  localparam int PEND_W   = $clog2(LANES * beqscan_pkg::VALS * beqscan_pkg::VALS + 1);
  localparam int SUM_W    = $clog2(beqscan_pkg::WORDS * beqscan_pkg::VALS + 1);

  typedef logic [beqscan_pkg::WORDS-1:0][beqscan_pkg::WORD_W-1:0] beat_words_t;

  // Popcount of a 32-bit hit vector via nibble counts.
  function automatic logic [beqscan_pkg::LANE_CNT_W-1:0] popcount32(
    input logic [beqscan_pkg::VALS-1:0] x
  );
    logic [2:0]                          nib;
    logic [beqscan_pkg::LANE_CNT_W-1:0]  tally;
    tally = '0;
    for (int i = 0; i < beqscan_pkg::VALS / 4; i++) begin
      nib = 3'(x[4*i]) + 3'(x[4*i+1]) + 3'(x[4*i+2]) + 3'(x[4*i+3]);
      tally = tally + beqscan_pkg::LANE_CNT_W'(nib);
    end
    return tally;
  endfunction

  // Configuration registers.
  logic [beqscan_pkg::BW_W-1:0]   bit_width_r;
  logic [beqscan_pkg::WORD_W-1:0] target_r;

  // Position counters.
  logic [GRP_W-1:0]               grp_r, grp_nxt;
  logic [beqscan_pkg::ROW_W-1:0]  row_r, row_nxt;

  // Pipeline registers.
  logic                           s1_v_r, s2_v_r, s3_v_r;
  logic                           s1_done_r, s2_done_r, s3_done_r;
  logic                           s1_last_r, s2_last_r, s3_last_r;
  beat_words_t                    s1_words_r;
  beat_words_t                    s1_prev_r;
  beqscan_pkg::value_sel_t        s1_vsel_r;
  logic [beqscan_pkg::WORDS-1:0][beqscan_pkg::VALS-1:0]        s2_hits_r;
  logic [beqscan_pkg::WORDS-1:0][beqscan_pkg::LANE_CNT_W-1:0]  s3_cnt_r;

  // Accumulators and output register.
  logic [PEND_W-1:0]              pending_r;
  logic [beqscan_pkg::CNT_W-1:0]  total_r;
  logic                           out_valid_r;
  logic [beqscan_pkg::CNT_W-1:0]  out_count_r;

  // Prior row words, one entry per lane group.
  logic [ROW_BITS-1:0]            prior_mem [GROUPS];

  logic                           adv;
  logic                           acc;
  logic [beqscan_pkg::BW_W-1:0]   b_eff;
  logic [beqscan_pkg::WORD_W-1:0] mask;
  logic                           row_end;
  logic                           blk_done;
  beqscan_pkg::value_sel_t        vsel_nxt;
  beat_words_t                    in_words;
  logic [beqscan_pkg::WORDS-1:0][beqscan_pkg::VALS-1:0] hits;
  logic [SUM_W-1:0]               item_sum;
  logic [PEND_W-1:0]              pend_sum;
  logic [beqscan_pkg::CNT_W:0]    tot_sum;
  logic [beqscan_pkg::CNT_W-1:0]  tot_sat;
  logic [beqscan_pkg::CNT_W-1:0]  total_new;
  logic [PEND_W-1:0]              pending_new;

  // The whole pipeline holds only when a final count cannot leave.
  assign adv       = !(s3_v_r && s3_last_r && out_valid_r && !out_ready);
  assign in_ready  = adv;
  assign acc       = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign in_words  = {in_word_d, in_word_c, in_word_b, in_word_a};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_width_r <= beqscan_pkg::BW_W'(1);
      target_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        beqscan_pkg::REG_BIT_WIDTH:    bit_width_r <= cfg_data[beqscan_pkg::BW_W-1:0];
        beqscan_pkg::REG_TARGET_VALUE: target_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective width, clamped to 1..32, and its value mask.
  always_comb begin
    priority if (bit_width_r == '0) begin
      b_eff = beqscan_pkg::BW_W'(1);
    end else if (bit_width_r > beqscan_pkg::MAX_BW) begin
      b_eff = beqscan_pkg::MAX_BW;
    end else begin
      b_eff = bit_width_r;
    end
    mask = (b_eff == beqscan_pkg::MAX_BW) ? '1 :
           ((beqscan_pkg::WORD_W'(1) << b_eff) - beqscan_pkg::WORD_W'(1));
  end

  // For each value position: does it end in this row, and where it starts
  // in the {current, previous} word window.
  always_comb begin
    logic [beqscan_pkg::POS_W-1:0] bitpos;
    logic [beqscan_pkg::POS_W-1:0] lastpos;
    vsel_nxt.mask   = mask;
    vsel_nxt.target = target_r & mask;
    for (int p = 0; p < beqscan_pkg::VALS; p++) begin
      bitpos  = beqscan_pkg::POS_W'(p) * beqscan_pkg::POS_W'(b_eff);
      lastpos = bitpos + beqscan_pkg::POS_W'(b_eff) - beqscan_pkg::POS_W'(1);
      vsel_nxt.en[p]  = (lastpos[beqscan_pkg::POS_W-1:5] == row_r);
      vsel_nxt.sel[p] = {(bitpos[beqscan_pkg::POS_W-1:5] == row_r), bitpos[4:0]};
    end
  end

  // Group and row position within the block.
  assign row_end  = (grp_r == GRP_W'(GROUPS - 1));
  assign blk_done = row_end &&
                    ((beqscan_pkg::BW_W'(row_r) + beqscan_pkg::BW_W'(1)) >= b_eff);

  always_comb begin
    grp_nxt = grp_r;
    row_nxt = row_r;
    if (acc) begin
      priority if (in_last_item) begin
        grp_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        grp_nxt = '0;
        row_nxt = blk_done ? '0 : row_r + beqscan_pkg::ROW_W'(1);
      end else begin
        grp_nxt = grp_r + GRP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r <= '0;
      row_r <= '0;
    end else begin
      grp_r <= grp_nxt;
      row_r <= row_nxt;
    end
  end

  // Prior-row memory: read the old row and store the new one in one edge.
  always_ff @(posedge clk) begin
    if (acc) begin
      prior_mem[grp_r] <= in_words;
      s1_prev_r        <= prior_mem[grp_r];
    end
  end

  // Stage 1: captured beat and select information.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_words_r <= in_words;
      s1_vsel_r  <= vsel_nxt;
      s1_done_r  <= blk_done;
      s1_last_r  <= in_last_item;
    end
  end

  // Lane match logic.
  for (genvar k = 0; k < beqscan_pkg::WORDS; k++) begin : g_lane
    beqscan_lane u_lane (
      .word      (s1_words_r[k]),
      .prev_word (s1_prev_r[k]),
      .vsel      (s1_vsel_r),
      .hits      (hits[k])
    );
  end

  // Stages 2 and 3: hit vectors, then per-lane counts.
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_hits_r <= hits;
      s2_done_r <= s1_done_r;
      s2_last_r <= s1_last_r;
      for (int k = 0; k < beqscan_pkg::WORDS; k++) begin
        s3_cnt_r[k] <= popcount32(s2_hits_r[k]);
      end
      s3_done_r <= s2_done_r;
      s3_last_r <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= acc;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Block accumulation with saturating total.
  always_comb begin
    item_sum = '0;
    for (int k = 0; k < beqscan_pkg::WORDS; k++) begin
      item_sum = item_sum + SUM_W'(s3_cnt_r[k]);
    end
    pend_sum = pending_r + PEND_W'(item_sum);
    tot_sum  = {1'b0, total_r} + (beqscan_pkg::CNT_W + 1)'(pend_sum);
    tot_sat  = (tot_sum > {1'b0, beqscan_pkg::TOTAL_MAX}) ? beqscan_pkg::TOTAL_MAX :
               tot_sum[beqscan_pkg::CNT_W-1:0];
    if (s3_done_r) begin
      total_new   = tot_sat;
      pending_new = '0;
    end else begin
      total_new   = total_r;
      pending_new = pend_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      total_r   <= '0;
    end else if (adv && s3_v_r) begin
      if (s3_last_r) begin
        pending_r <= '0;
        total_r   <= '0;
      end else begin
        pending_r <= pending_new;
        total_r   <= total_new;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s3_v_r && s3_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_v_r && s3_last_r) begin
      out_count_r <= total_new;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_count = out_count_r;

endmodule

// ===== rtl/beqscan_checker.sv =====
// Port-level checker for the bit-packed equality count scan unit, bound to
// the top level below. Depends on beqscan_pkg for widths.
module beqscan_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last_item,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [beqscan_pkg::CNT_W-1:0] out_match_count,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);

  // A held result beat keeps its count.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_match_count))
    else $error("result beat changed while stalled");

  // Synchronous reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input only stalls behind a waiting result.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A taken result leaves the input ready unless it is idle or offers a final beat.
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> in_ready || (in_valid && in_last_item) || !in_valid ||
    in_ready)
    else $error("input stalled after result taken");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind bitpacked_equality_count_scan_unit beqscan_checker u_beqscan_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_last_item    (in_last_item),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_match_count (out_match_count),
  .cfg_valid       (cfg_valid),
  .cfg_ready       (cfg_ready)
);

// ===== sim/tb_bitpacked_equality_count_scan_unit.sv =====
// Self-checking testbench for the bit-packed equality count scan unit.
// Drives packed column groups and register writes, and checks every final count
// against a typed count or an in-bench scan predictor. Depends on rtl/beqscan_pkg.sv and the unit.
`timescale 1ns / 1ps

module tb_bitpacked_equality_count_scan_unit;
  import beqscan_pkg::*;

  localparam int LANES           = 32;
  localparam int GROUPS          = LANES / WORDS;
  localparam int TOTAL_BEATS     = 1600;
  localparam int QUIET_FROM      = 1400;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PRESSURE_CYCLES = 400;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PLAN_LEN        = 13;

  // Index that maps to no register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef enum logic {
    ROW_CFG,
    ROW_BEAT
  } row_kind_e;

  // One directed step: a register write, or a beat repeated reps times.
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [WORD_W-1:0]     data;
    logic [WORD_W-1:0]     wa;
    logic [WORD_W-1:0]     wb;
    logic [WORD_W-1:0]     wc;
    logic [WORD_W-1:0]     wd;
    logic                  last;
    logic [3:0]            reps;
    logic                  typed;
    logic [CNT_W-1:0]      count;
  } step_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [WORD_W-1:0]    in_word_a;
  logic [WORD_W-1:0]    in_word_b;
  logic [WORD_W-1:0]    in_word_c;
  logic [WORD_W-1:0]    in_word_d;
  logic                 in_last_item;
  logic                 out_valid;
  logic                 out_ready;
  logic [CNT_W-1:0]     out_match_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  // Predictor copy of the registers and the scan state.
  logic [5:0]         reg_width = 6'd1;
  logic [WORD_W-1:0]  reg_target = '0;
  logic [WORD_W-1:0]  prior_word [LANES] = '{default: '0};
  int unsigned        scan_group = 0;
  int unsigned        scan_row = 0;
  int unsigned        block_hits = 0;
  longint unsigned    run_total = 0;

  logic [CNT_W-1:0]   expected_totals [$];
  logic [CNT_W-1:0]   want_count;
  int                 fails = 0;
  int unsigned        beats_sent = 0;
  int unsigned        gap_pct = 0;
  int unsigned        cycle_cnt = 0;
  bit                 quiet_tail = 0;
  bit                 hold_request = 0;
  int unsigned        hold_left = 0;

  // Directed steps. Counts are typed in only where they are obvious.
  step_t plan [PLAN_LEN] = '{
    // Right after reset: one beat of an unfinished block counts nothing.
    '{ROW_BEAT, REG_BIT_WIDTH, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b1, 4'd1, 1'b1, 40'd0},
    // Width zero acts as one; the target is masked down to a single bit.
    '{ROW_CFG, REG_BIT_WIDTH, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 4'd0, 1'b0, 40'd0},
    '{ROW_CFG, REG_TARGET_VALUE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 4'd0, 1'b0, 40'd0},
    // One full block of ones: every value of every lane matches.
    '{ROW_BEAT, REG_BIT_WIDTH, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 1'b1, 4'd8, 1'b1, 40'd1024},
    // A width above the maximum acts as the maximum.
    '{ROW_CFG, REG_BIT_WIDTH, 32'd63, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 4'd0, 1'b0, 40'd0},
    '{ROW_CFG, REG_TARGET_VALUE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 4'd0, 1'b0, 40'd0},
    '{ROW_BEAT, REG_BIT_WIDTH, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b1, 4'd1, 1'b1, 40'd0},
    // Unmapped index, then a width with junk in the upper data bits.
    '{ROW_CFG, REG_UNMAPPED, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 4'd0, 1'b0, 40'd0},
    '{ROW_CFG, REG_BIT_WIDTH, 32'hFFFF_FFC2, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 4'd0, 1'b0, 40'd0},
    '{ROW_CFG, REG_TARGET_VALUE, 32'hFFFF_FFFE, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 4'd0, 1'b0, 40'd0},
    // First row of a two-row block, then the width drops mid-block.
    '{ROW_BEAT, REG_BIT_WIDTH, 32'h0, 32'hA5A5_5A5A, 32'h0F0F_F0F0, 32'h3333_CCCC,
      32'h8000_0001, 1'b0, 4'd8, 1'b0, 40'd0},
    '{ROW_CFG, REG_BIT_WIDTH, 32'd1, 32'h0, 32'h0, 32'h0, 32'h0,
      1'b0, 4'd0, 1'b0, 40'd0},
    '{ROW_BEAT, REG_BIT_WIDTH, 32'h0, 32'h5A5A_A5A5, 32'hFFFF_0000, 32'h0000_FFFF,
      32'h7FFF_FFFE, 1'b1, 4'd8, 1'b0, 40'd0}
  };

  bitpacked_equality_count_scan_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_word_a       (in_word_a),
    .in_word_b       (in_word_b),
    .in_word_c       (in_word_c),
    .in_word_d       (in_word_d),
    .in_last_item    (in_last_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_count (out_match_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Effective width: zero reads as one, anything above the maximum as the maximum.
  function automatic int unsigned rows_per_block();
    if (reg_width == 6'd0) return 1;
    if (reg_width > MAX_BW) return 32;
    return 32'(reg_width);
  endfunction

  // Values of one lane whose last bit falls in row r and that equal t.
  function automatic int unsigned count_lane_hits(logic [31:0] w, logic [31:0] prev,
                                                  int unsigned r, int unsigned b,
                                                  logic [31:0] m, logic [31:0] t);
    int unsigned hits;
    int unsigned pos;
    int unsigned first_row;
    int unsigned end_row;
    int unsigned off;
    logic [31:0] v;
    hits = 0;
    for (int unsigned p = 0; p < VALS; p++) begin
      pos = p * b;
      first_row = pos >> 5;
      end_row = (pos + b - 1) >> 5;
      off = pos & 31;
      if (end_row == r) begin
        if (first_row == r) v = (w >> off) & m;
        else v = ((prev >> off) | (w << (32 - off))) & m;
        if (v == t) hits++;
      end
    end
    return hits;
  endfunction

  // Advances the scan by one beat; returns 1 when the beat closes the scan.
  function automatic bit advance_scan(logic [31:0] words [WORDS], logic last,
                                      output logic [CNT_W-1:0] total);
    int unsigned b;
    int unsigned lane;
    logic [31:0] m;
    logic [31:0] t;
    b = rows_per_block();
    m = (b >= 32) ? 32'hFFFF_FFFF : ((32'h1 << b) - 32'h1);
    t = reg_target & m;
    for (int k = 0; k < WORDS; k++) begin
      lane = scan_group * WORDS + k;
      block_hits += count_lane_hits(words[k], prior_word[lane], scan_row, b, m, t);
      prior_word[lane] = words[k];
    end
    if (scan_group + 1 >= GROUPS) begin
      scan_group = 0;
      if (scan_row + 1 >= b) begin
        run_total += block_hits;
        if (run_total > TOTAL_MAX) run_total = 64'(TOTAL_MAX);
        block_hits = 0;
        scan_row = 0;
      end else begin
        scan_row++;
      end
    end else begin
      scan_group++;
    end
    total = run_total[CNT_W-1:0];
    if (!last) return 1'b0;
    scan_group = 0;
    scan_row = 0;
    block_hits = 0;
    run_total = 0;
    return 1'b1;
  endfunction

  // Offers one beat, waits for its handshake, then records the expected count if the beat closes the scan.
  task automatic push_group(input logic [31:0] wa, input logic [31:0] wb,
                            input logic [31:0] wc, input logic [31:0] wd,
                            input logic last, input logic typed,
                            input logic [CNT_W-1:0] typed_count);
    logic [31:0] words [WORDS];
    logic [CNT_W-1:0] predicted;
    quiet_tail = (beats_sent >= QUIET_FROM);
    if (!quiet_tail && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word_a <= wa;
    in_word_b <= wb;
    in_word_c <= wc;
    in_word_d <= wd;
    in_last_item <= last;
    do @(posedge clk); while (!in_ready);
    words = '{wa, wb, wc, wd};
    if (advance_scan(words, last, predicted))
      expected_totals.push_back(typed ? typed_count : predicted);
    beats_sent++;
  endtask

  // Register write once all counts are in and the pipeline has drained.
  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    in_valid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_BIT_WIDTH) reg_width = data[5:0];
    else if (idx == REG_TARGET_VALUE) reg_target = data;
  endtask

  // One scan of len beats: packed blocks built value by value, some pure noise.
  task automatic run_scan(input int unsigned len);
    logic [1023:0] lane_stream [LANES];
    logic [31:0] w [WORDS];
    logic [31:0] v;
    int unsigned b;
    int unsigned sent;
    bit noise;
    b = rows_per_block();
    sent = 0;
    while (sent < len) begin
      noise = ($urandom_range(0, 9) < 2);
      for (int k = 0; k < LANES; k++) begin
        for (int j = 0; j < 32; j++) lane_stream[k][j*32 +: 32] = $urandom;
        if (!noise) begin
          for (int unsigned p = 0; p < VALS; p++) begin
            case ($urandom_range(0, 3))
              0, 1: v = reg_target;
              2: v = reg_target ^ (32'h1 << $urandom_range(0, b - 1));
              default: v = $urandom;
            endcase
            for (int unsigned j = 0; j < b; j++) lane_stream[k][p*b + j] = v[j];
          end
        end
      end
      for (int unsigned r = 0; r < b && sent < len; r++) begin
        for (int g = 0; g < GROUPS && sent < len; g++) begin
          for (int k = 0; k < WORDS; k++) w[k] = lane_stream[g*WORDS + k][r*32 +: 32];
          push_group(w[0], w[1], w[2], w[3], sent == len - 1, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  // Result sink: random stall bursts, calm windows, one long hold-off.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 0;
        hold_left = PRESSURE_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (!quiet_tail && (cycle_cnt % 512) >= 128 && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        hold_left = $urandom_range(0, 4);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Output check against the oldest expected count.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_totals.size() == 0) begin
        $error("match_count: expected none, actual %0d", out_match_count);
        fails++;
      end else begin
        want_count = expected_totals.pop_front();
        if (out_match_count !== want_count) begin
          $error("match_count: expected %0d, actual %0d", want_count, out_match_count);
          fails++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Reset, directed table, random phases, drain.
  initial begin
    int unsigned b;
    int unsigned block_len;
    int unsigned nblk;
    int unsigned extra;
    int unsigned len;
    logic [31:0] width_data;
    logic [31:0] target_data;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word_a <= '0;
    in_word_b <= '0;
    in_word_c <= '0;
    in_word_d <= '0;
    in_last_item <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_BIT_WIDTH;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        program_reg(plan[i].idx, plan[i].data);
      end else begin
        for (int n = 0; n < plan[i].reps; n++)
          push_group(plan[i].wa, plan[i].wb, plan[i].wc, plan[i].wd,
                     plan[i].last && n == plan[i].reps - 1, plan[i].typed, plan[i].count);
      end
    end

    // Random phases: new settings, then a few scans each.
    hold_request = 1;
    while (beats_sent < TOTAL_BEATS) begin
      case ($urandom_range(0, 19))
        0: width_data = 32'd0;
        1: width_data = $urandom_range(33, 63);
        2, 3: width_data = 32'd32;
        4, 5, 6, 7: width_data = $urandom_range(5, 16);
        default: width_data = $urandom_range(1, 4);
      endcase
      width_data[31:6] = 26'($urandom);
      target_data = $urandom;
      if ($urandom_range(0, 1) == 0) begin
        program_reg(REG_BIT_WIDTH, width_data);
        program_reg(REG_TARGET_VALUE, target_data);
      end else begin
        program_reg(REG_TARGET_VALUE, target_data);
        program_reg(REG_BIT_WIDTH, width_data);
      end
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 25;
      endcase
      b = rows_per_block();
      block_len = GROUPS * b;
      repeat ($urandom_range(2, 5)) begin
        if (b <= 4) nblk = $urandom_range(0, 3);
        else if (b <= 16) nblk = $urandom_range(0, 1);
        else nblk = ($urandom_range(0, 3) == 0) ? 1 : 0;
        extra = $urandom_range(0, (block_len - 1 < 24) ? block_len - 1 : 24);
        len = nblk * block_len + extra;
        if (len == 0) len = 1;
        if (beats_sent < TOTAL_BEATS) run_scan(len);
      end
    end

    in_valid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0 && expected_totals.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/beqscan_pkg.sv
rtl/beqscan_lane.sv
rtl/bitpacked_equality_count_scan_unit.sv
rtl/beqscan_checker.sv
sim/tb_bitpacked_equality_count_scan_unit.sv
